/* hw/rtl/pti_pkg.sv */
package pti_pkg;

	localparam int KEY_W = 16;
	localparam int VAL_W = 32;
	localparam int ACT_W = 2;
	localparam int STAT_W = 3;

	localparam logic [ACT_W-1:0] ACT_WR_TIME  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_WR_BYTES = 2'd1;

	localparam logic [STAT_W-1:0] ST_WRITE_OK = 3'd0;
	localparam logic [STAT_W-1:0] ST_HIT      = 3'd1;
	localparam logic [STAT_W-1:0] ST_INTERP   = 3'd2;
	localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd3;
	localparam logic [STAT_W-1:0] ST_FEW      = 3'd4;
	localparam logic [STAT_W-1:0] ST_FULL     = 3'd5;

	// one table entry as it moves along the ring of cells
	typedef struct packed {
		logic             used;
		logic             tv;
		logic             bv;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] tval;
		logic [VAL_W-1:0] bval;
	} entry_t;

	// write command broadcast to all cells while the ring rotates
	typedef struct packed {
		logic             en;
		logic             is_bytes;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] val;
	} wr_cmd_t;

endpackage

/* hw/rtl/pti_cell.sv */
// One storage cell of the rotating ring. Every cycle that shift is high, the entry moves one step
// towards the head; a write command updates the entry as it comes in from the previous cell.
module pti_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            shift,
	input  pti_pkg::wr_cmd_t wr,
	input  logic            append,
	input  pti_pkg::entry_t prev,
	output pti_pkg::entry_t cur
);

	logic                      used_q, tv_q, bv_q;
	logic [pti_pkg::KEY_W-1:0] key_q;
	logic [pti_pkg::VAL_W-1:0] tval_q, bval_q;
	pti_pkg::entry_t nxt;

	always_comb begin
		nxt = prev;
		if (wr.en && prev.used && prev.key == wr.key) begin
			if (wr.is_bytes) begin
				nxt.bval = wr.val;
				nxt.bv = 1'b1;
			end else begin
				nxt.tval = wr.val;
				nxt.tv = 1'b1;
			end
		end
		if (append) begin
			nxt.used = 1'b1;
			nxt.key = wr.key;
			nxt.tv = !wr.is_bytes;
			nxt.bv = wr.is_bytes;
			nxt.tval = wr.val;
			nxt.bval = wr.val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			tv_q <= 1'b0;
			bv_q <= 1'b0;
		end else if (shift) begin
			used_q <= nxt.used;
			tv_q <= nxt.tv;
			bv_q <= nxt.bv;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			key_q <= nxt.key;
			tval_q <= nxt.tval;
			bval_q <= nxt.bval;
		end
	end

	assign cur = {used_q, tv_q, bv_q, key_q, tval_q, bval_q};

endmodule

/* hw/rtl/pti_div.sv */
// Restoring divider, one quotient bit per cycle. Unsigned numerator and
// denominator.
module pti_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num,
	input  logic [16:0] den,
	output logic        busy,
	output logic [63:0] quo
);

	logic [6:0]  cnt_q;
	logic [63:0] q_q;
	logic [17:0] rem_q;
	logic [16:0] den_q;
	logic [17:0] trial;

	assign trial = {rem_q[16:0], q_q[63]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 7'd64;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (cnt_q != '0) begin
			if (!trial[17]) begin
				rem_q <= trial;
				q_q <= {q_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[16:0], q_q[63]};
				q_q <= {q_q[62:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != '0);
	assign quo = q_q;

endmodule

/* hw/rtl/profile_table_interpolator_core.sv */
// Piecewise-linear profile table. Entries live in a ring of TABLE_ENTRIES cells
// that rotates one step a cycle while it scans; a write lets the ring turn once.
// A query turns the ring twice to pick the nearest and second-nearest keys,
// then runs two 64-step serial divisions (time, then bytes); it ends before
// the divisions on a hit or an error. A result that cannot leave waits in
// the output state until the output register is free.
// One item is in work at a time; the result sits in an output register while
// the next item is taken.
module profile_table_interpolator_core #(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,  // action[1:0], batch_key[17:2], entry_value[49:18]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata   // status[2:0], time_estimate[34:3],
	                              // bytes_estimate[66:35], clamped[67]
);

	localparam int CW = $clog2(TABLE_ENTRIES + 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_EVAL = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	logic [2:0]  st_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] count_q;
	logic        pass_q;     // 0 first scan, 1 second scan
	logic        div_sel_q;  // 0 time, 1 bytes
	logic        is_wr_q;
	logic        is_bytes_q;
	logic [15:0] key_q;
	logic [31:0] val_q;
	logic        found_q;
	logic        a_ok_q, b_ok_q;
	pti_pkg::entry_t a_q, b_q;
	logic [16:0] ad_q, bd_q;
	logic [31:0] cur_t_q, cur_b_q;
	logic [31:0] res_t_q;
	logic        clamp_q;
	logic [2:0]  status_q;
	logic        out_v_q;
	logic [71:0] out_q;

	pti_pkg::entry_t ring [TABLE_ENTRIES];
	pti_pkg::entry_t head;
	pti_pkg::wr_cmd_t wr;
	logic shift, append;

	assign head = ring[TABLE_ENTRIES-1];
	assign shift = (st_q == S_SCAN);
	assign wr = '{en: shift && is_wr_q, is_bytes: is_bytes_q, key: key_q, val: val_q};

	genvar g;
	generate
		for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
			pti_cell u_cell (
				.clk(clk), .arst_n(arst_n), .shift(shift), .wr(wr),
				.append((g == 0) ? append : 1'b0),
				.prev((g == 0) ? head : ring[(g == 0) ? 0 : g-1]),
				.cur(ring[g])
			);
		end
	endgenerate

	// used entries keep the top slots, so the first free slot reaches the head
	// right after every used entry has been compared; a new key goes in there
	logic last_step;
	logic hit_now;
	assign last_step = (cnt_q == CW'(TABLE_ENTRIES - 1));
	assign hit_now = head.used && head.key == key_q;
	assign append = shift && is_wr_q && !found_q && (cnt_q == count_q);

	// distance of head entry
	logic [16:0] d;
	assign d = (head.key > key_q) ? {1'b0, head.key - key_q} : {1'b0, key_q - head.key};
	logic better_a, better_b, cand;
	assign cand = head.used && head.tv;
	assign better_a = !a_ok_q || d < ad_q || (d == ad_q && head.key > a_q.key);
	assign better_b = !b_ok_q || d < bd_q || (d == bd_q && head.key > b_q.key);

	// lerp numerator with k1=a, k2=b: v1*(k2-k1) + (v2-v1)*(q-k1)
	logic [31:0] v1, v2;
	logic signed [17:0] dk, dq;
	logic signed [33:0] dv;
	logic signed [66:0] num_s;
	logic [63:0] num_mag;
	logic neg;
	logic [16:0] den_mag;
	assign v1 = div_sel_q ? a_q.bval : a_q.tval;
	assign v2 = div_sel_q ? b_q.bval : b_q.tval;
	assign dk = $signed({2'b0, b_q.key}) - $signed({2'b0, a_q.key});
	assign dq = $signed({2'b0, key_q}) - $signed({2'b0, a_q.key});
	assign dv = $signed({2'b0, v2}) - $signed({2'b0, v1});
	always_comb begin
		num_s = 67'($signed({1'b0, v1}) * dk) + 67'(dv * dq);
		if (dk < 0) num_s = -num_s;
		neg = num_s[66];
		num_mag = neg ? 64'(-num_s) : num_s[63:0];
		den_mag = dk[17] ? 17'(-dk) : dk[16:0];
	end

	logic div_start, div_busy;
	logic [63:0] quo;
	logic neg_q;
	pti_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(num_mag),
		.den(den_mag), .busy(div_busy), .quo(quo)
	);
	assign div_start = (st_q == S_EVAL) && a_ok_q && b_ok_q;

	logic [31:0] sat;
	logic sat_c;
	always_comb begin
		if (neg_q && quo != '0) begin
			sat = '0; sat_c = 1'b1;
		end else if (quo[63:32] != '0) begin
			sat = '1; sat_c = 1'b1;
		end else begin
			sat = quo[31:0]; sat_c = 1'b0;
		end
	end

	logic out_free;
	assign out_free = !out_v_q || m_tready;
	assign s_tready = (st_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			cnt_q <= '0;
			count_q <= '0;
			pass_q <= 1'b0;
			div_sel_q <= 1'b0;
			out_v_q <= 1'b0;
			cur_t_q <= '0;
			cur_b_q <= '0;
			found_q <= 1'b0;
			a_ok_q <= 1'b0;
			b_ok_q <= 1'b0;
			a_q <= '0;
			b_q <= '0;
			ad_q <= '0;
			bd_q <= '0;
			neg_q <= 1'b0;
			res_t_q <= '0;
			clamp_q <= 1'b0;
			status_q <= '0;
		end else begin
			if (out_v_q && m_tready && st_q != S_OUT) out_v_q <= 1'b0;
			unique case (st_q)
				S_IDLE: begin
					if (s_tvalid) begin
						st_q <= S_SCAN;
						cnt_q <= '0;
						pass_q <= 1'b0;
						div_sel_q <= 1'b0;
						found_q <= 1'b0;
						a_ok_q <= 1'b0;
						b_ok_q <= 1'b0;
						clamp_q <= 1'b0;
					end
				end
				S_SCAN: begin
					cnt_q <= last_step ? '0 : cnt_q + CW'(1);
					if (is_wr_q) begin
						if (hit_now) found_q <= 1'b1;
					end else if (cand) begin
						if (!pass_q) begin
							if (better_a) begin
								a_ok_q <= 1'b1; a_q <= head; ad_q <= d;
							end
						end else if (!(head.key == a_q.key) && better_b) begin
							b_ok_q <= 1'b1; b_q <= head; bd_q <= d;
						end
					end
					if (last_step) begin
						if (!is_wr_q && !pass_q) begin
							pass_q <= 1'b1;
						end else begin
							st_q <= S_EVAL;
						end
					end
				end
				S_EVAL: begin
					if (is_wr_q) begin
						st_q <= S_OUT;
						if (found_q) status_q <= pti_pkg::ST_WRITE_OK;
						else if (count_q == CW'(TABLE_ENTRIES)) status_q <= pti_pkg::ST_FULL;
						else begin
							status_q <= pti_pkg::ST_WRITE_OK;
							count_q <= count_q + CW'(1);
						end
					end else if (!a_ok_q) begin
						status_q <= pti_pkg::ST_EMPTY; st_q <= S_OUT;
					end else if (a_q.key == key_q) begin
						st_q <= S_OUT;
						if (!a_q.bv) status_q <= pti_pkg::ST_FEW;
						else begin
							status_q <= pti_pkg::ST_HIT;
							cur_t_q <= a_q.tval; cur_b_q <= a_q.bval;
						end
					end else if (!b_ok_q || !a_q.bv || !b_q.bv) begin
						status_q <= pti_pkg::ST_FEW; st_q <= S_OUT;
					end else begin
						neg_q <= neg;
						st_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (!div_busy) begin
						if (!div_sel_q) begin
							res_t_q <= sat; clamp_q <= sat_c;
							div_sel_q <= 1'b1;
							st_q <= S_EVAL;
						end else begin
							cur_t_q <= res_t_q; cur_b_q <= sat;
							clamp_q <= clamp_q | sat_c;
							status_q <= pti_pkg::ST_INTERP;
							st_q <= S_OUT;
						end
					end
				end
				S_OUT: begin
					if (out_free) begin
						out_v_q <= 1'b1;
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == S_IDLE && s_tvalid) begin
			is_wr_q <= (s_tdata[1:0] == pti_pkg::ACT_WR_TIME) ||
				(s_tdata[1:0] == pti_pkg::ACT_WR_BYTES);
			is_bytes_q <= (s_tdata[1:0] == pti_pkg::ACT_WR_BYTES);
			key_q <= s_tdata[17:2];
			val_q <= s_tdata[49:18];
		end
		if (st_q == S_OUT && out_free)
			out_q <= {4'b0, clamp_q, cur_b_q, cur_t_q, status_q};
	end

	assign m_tvalid = out_v_q;
	assign m_tdata = out_q;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata));
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_ENTRIES));
	a_state_legal: assert property (@(posedge clk) disable iff (!arst_n)
		st_q <= S_OUT);
	a_status_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2:0] <= pti_pkg::ST_FULL);
	a_append_room: assert property (@(posedge clk) disable iff (!arst_n)
		append |-> count_q < CW'(TABLE_ENTRIES));

endmodule
